/* src/bpuf_pkg.sv */
// shared types and constants of the bottleneck path union-find block
package bpuf_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int MAX_EDGES    = 1024;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VTX_W + 1;
	localparam int EADDR_W      = $clog2(MAX_EDGES);
	localparam int ETOT_W       = EADDR_W + 1;
	localparam int COST_W       = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [VTX_W-1:0]  end_a;
		logic [VTX_W-1:0]  end_b;
		logic [COST_W-1:0] cost;
	} edge_t;

	typedef struct packed {
		logic               en;
		logic [EADDR_W-1:0] addr;
		edge_t              data;
	} edge_wr_t;

	typedef struct packed {
		logic             en;
		logic [VTX_W-1:0] addr;
		logic [VTX_W-1:0] data;
	} par_wr_t;

endpackage

/* src/bpuf_edge_mem.sv */
// sorted edge store memory, one write and one registered read port
module bpuf_edge_mem (
	input  logic                      clk,
	input  bpuf_pkg::edge_wr_t        wr,
	input  logic [bpuf_pkg::EADDR_W-1:0] rd_addr,
	output bpuf_pkg::edge_t           rd_data
);
	import bpuf_pkg::*;

	edge_t mem_q [MAX_EDGES];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* src/bpuf_parent_mem.sv */
// union-find parent table memory, one write and one registered read port
module bpuf_parent_mem (
	input  logic                        clk,
	input  bpuf_pkg::par_wr_t           wr,
	input  logic [bpuf_pkg::VTX_W-1:0]  rd_addr,
	output logic [bpuf_pkg::VTX_W-1:0]  rd_data
);
	import bpuf_pkg::*;

	logic [VTX_W-1:0] mem_q [MAX_VERTICES];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* src/bottleneck_path_union_find_unit.sv */
// top level: sequencer for sorted edge loads and minimax path queries
//
//  channel | signals                                   | dir | handshake
//  in      | op vertex_a vertex_b edge_cost            | in  | in_valid / in_stall
//  out     | status path_found bottleneck_cost         | out | out_valid / out_stall
//  cfg     | cfg_data (vertex_count)                   | in  | cfg_valid / cfg_ready
//
// a load reads and compares stored edges from the top down, moving each of higher cost
// up one slot, then writes the new edge; no compare is made once slot 0 is reached
// a query first writes the parent table, then per edge makes up to 4 finds, each with a
// read and check per parent hop and per compressed hop, through the one parent memory port
// a range or full error goes straight to done; results leave through one output register
// reset clears the edge count and sets vertex_count to 256; no clearing pass is needed
// in_stall is high while a beat is being worked on or its result cannot be placed
module bottleneck_path_union_find_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [8:0]                   vertex_a,
	input  logic [8:0]                   vertex_b,
	input  logic [15:0]                  edge_cost,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         path_found,
	output logic [15:0]                  bottleneck_cost,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [8:0]                   cfg_data
);
	import bpuf_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LD_RD  = 4'd1;
	localparam logic [3:0] S_LD_CMP = 4'd2;
	localparam logic [3:0] S_LD_WR  = 4'd3;
	localparam logic [3:0] S_QI     = 4'd4;
	localparam logic [3:0] S_Q_EDGE = 4'd5;
	localparam logic [3:0] S_Q_EWT  = 4'd6;
	localparam logic [3:0] S_F_RD   = 4'd7;
	localparam logic [3:0] S_F_CHK  = 4'd8;
	localparam logic [3:0] S_C_RD   = 4'd9;
	localparam logic [3:0] S_C_CHK  = 4'd10;
	localparam logic [3:0] S_UNION  = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	localparam logic [1:0] PH_U  = 2'd0;
	localparam logic [1:0] PH_W  = 2'd1;
	localparam logic [1:0] PH_QA = 2'd2;
	localparam logic [1:0] PH_QB = 2'd3;

	logic [3:0]         state_q;
	logic [1:0]         phase_q;
	logic [VCNT_W-1:0]  vcount_q;
	logic [ETOT_W-1:0]  total_q;
	logic [ETOT_W-1:0]  pos_q;
	logic [ETOT_W-1:0]  e_q;
	logic [VCNT_W-1:0]  i_q;
	logic [VTX_W-1:0]   va_q, vb_q, u_q, w_q, r_q, cur_q, ru_q;
	logic [COST_W-1:0]  cost_q, ecost_q;
	logic [1:0]         res_status_q;
	logic               res_found_q;
	logic [COST_W-1:0]  res_cost_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [COST_W-1:0]  bcost_q;

	logic [VCNT_W-1:0]  live_n;
	logic               in_acc, range_bad, out_free;
	logic [ETOT_W-1:0]  pos_m1;
	edge_wr_t           edge_wr;
	edge_t              edge_rd;
	logic [EADDR_W-1:0] edge_rd_addr;
	par_wr_t            par_wr;
	logic [VTX_W-1:0]   par_rd, par_rd_addr;

	// live vertex count and input checks
	assign live_n    = (vcount_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_q;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign range_bad = (vertex_a == '0) || (vertex_b == '0) ||
	                   (vertex_a > live_n) || (vertex_b > live_n);
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_m1    = pos_q - ETOT_W'(1);
	assign cfg_ready = 1'b1;

	// edge memory ports
	always_comb begin
		edge_wr.en   = (state_q == S_LD_WR) ||
		               ((state_q == S_LD_CMP) && (edge_rd.cost > cost_q));
		edge_wr.addr = pos_q[EADDR_W-1:0];
		edge_wr.data = (state_q == S_LD_WR) ? edge_t'{va_q, vb_q, cost_q} : edge_rd;
		edge_rd_addr = (state_q == S_LD_RD) ? pos_m1[EADDR_W-1:0] : e_q[EADDR_W-1:0];
	end

	// parent memory ports
	always_comb begin
		par_wr.en   = 1'b0;
		par_wr.addr = i_q[VTX_W-1:0];
		par_wr.data = i_q[VTX_W-1:0];
		case (state_q)
			S_QI: begin
				par_wr.en = 1'b1;
			end
			S_C_CHK: begin
				par_wr.en   = (par_rd != r_q);
				par_wr.addr = cur_q;
				par_wr.data = r_q;
			end
			S_UNION: begin
				par_wr.en   = (ru_q != r_q);
				par_wr.addr = ru_q;
				par_wr.data = r_q;
			end
			default: begin
			end
		endcase
		par_rd_addr = (state_q == S_C_RD) ? cur_q : r_q;
	end

	bpuf_edge_mem u_edge_mem (
		.clk     (clk),
		.wr      (edge_wr),
		.rd_addr (edge_rd_addr),
		.rd_data (edge_rd)
	);

	bpuf_parent_mem u_parent_mem (
		.clk     (clk),
		.wr      (par_wr),
		.rd_addr (par_rd_addr),
		.rd_data (par_rd)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCNT_W'(MAX_VERTICES);
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						va_q        <= VTX_W'(vertex_a - 9'd1);
						vb_q        <= VTX_W'(vertex_b - 9'd1);
						cost_q      <= edge_cost;
						pos_q       <= total_q;
						i_q         <= '0;
						e_q         <= '0;
						res_found_q <= 1'b0;
						res_cost_q  <= '0;
						res_status_q <= ST_OK;
						if (range_bad) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else if (op == OP_LOAD) begin
							if (total_q == ETOT_W'(MAX_EDGES)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_LD_RD;
							end
						end else begin
							state_q <= S_QI;
						end
					end
				end
				S_LD_RD: begin
					state_q <= (pos_q == '0) ? S_LD_WR : S_LD_CMP;
				end
				S_LD_CMP: begin
					if (edge_rd.cost > cost_q) begin
						pos_q   <= pos_m1;
						state_q <= S_LD_RD;
					end else begin
						state_q <= S_LD_WR;
					end
				end
				S_LD_WR: begin
					total_q <= total_q + ETOT_W'(1);
					state_q <= S_DONE;
				end
				S_QI: begin
					i_q <= i_q + VCNT_W'(1);
					if (i_q == live_n - VCNT_W'(1)) begin
						state_q <= S_Q_EDGE;
					end
				end
				S_Q_EDGE: begin
					state_q <= (e_q == total_q) ? S_DONE : S_Q_EWT;
				end
				S_Q_EWT: begin
					u_q     <= edge_rd.end_a;
					w_q     <= edge_rd.end_b;
					ecost_q <= edge_rd.cost;
					state_q <= S_F_RD;
					if (({1'b0, edge_rd.end_a} < live_n) && ({1'b0, edge_rd.end_b} < live_n)) begin
						phase_q <= PH_U;
						r_q     <= edge_rd.end_a;
						cur_q   <= edge_rd.end_a;
					end else begin
						phase_q <= PH_QA;
						r_q     <= va_q;
						cur_q   <= va_q;
					end
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (par_rd == r_q) begin
						state_q <= S_C_RD;
					end else begin
						r_q     <= par_rd;
						state_q <= S_F_RD;
					end
				end
				S_C_RD: begin
					state_q <= S_C_CHK;
				end
				S_C_CHK: begin
					if (par_rd != r_q) begin
						cur_q   <= par_rd;
						state_q <= S_C_RD;
					end else begin
						// root found and path flattened, go on by phase
						case (phase_q)
							PH_U: begin
								ru_q    <= r_q;
								phase_q <= PH_W;
								r_q     <= w_q;
								cur_q   <= w_q;
								state_q <= S_F_RD;
							end
							PH_W: begin
								state_q <= S_UNION;
							end
							PH_QA: begin
								ru_q    <= r_q;
								phase_q <= PH_QB;
								r_q     <= vb_q;
								cur_q   <= vb_q;
								state_q <= S_F_RD;
							end
							default: begin
								if (ru_q == r_q) begin
									res_found_q <= 1'b1;
									res_cost_q  <= ecost_q;
									state_q     <= S_DONE;
								end else begin
									e_q     <= e_q + ETOT_W'(1);
									state_q <= S_Q_EDGE;
								end
							end
						endcase
					end
				end
				S_UNION: begin
					phase_q <= PH_QA;
					r_q     <= va_q;
					cur_q   <= va_q;
					state_q <= S_F_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
			bcost_q  <= res_cost_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign path_found      = found_q;
	assign bottleneck_cost = bcost_q;

	// checks
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= ETOT_W'(MAX_EDGES))
		else $error("edge count beyond store depth");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == ST_OK)
		else $error("path reported with error status");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != $past(total_q) |-> $past(state_q) == S_LD_WR)
		else $error("edge count moved outside an insert");
	a_no_cost_wo_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> bcost_q == '0)
		else $error("cost without path");
endmodule
